>>> hw/rtl/itg_pkg.sv
// Package for the interleave table generator: request and result types,
// sequencer control word and status types, and the microcode program.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package itg_pkg;

    localparam int MAX_SECTORS = 64;
    localparam int SLOT_W      = $clog2(MAX_SECTORS);
    localparam int COUNT_W     = SLOT_W + 1;
    localparam int UPC_W       = 4;

    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        logic [6:0] sectors_per_track;
        logic [7:0] start_sector;
        logic [7:0] interleave;
    } itg_req_t;

    typedef struct packed {
        logic [5:0] slot_index;
        logic [7:0] sector_number;
        logic       last;
    } itg_res_t;

    // Datapath operations selected by one microcode step.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_PLACE,
        OP_PROBE,
        OP_EMIT_INIT,
        OP_EMIT
    } itg_op_t;

    // Jump conditions; the jump is taken when the condition holds.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_N_ZERO,
        C_CLR_MORE,
        C_PLACE_DONE,
        C_NO_WRAP,
        C_PROBE_DONE,
        C_OUT_BUSY,
        C_EMIT_MORE
    } itg_cond_t;

    typedef struct packed {
        itg_op_t   op;
        itg_cond_t cond;
        upc_t      target;
    } itg_ctl_t;

    typedef struct packed {
        logic n_zero;
        logic clr_more;
        logic place_done;
        logic no_wrap;
        logic probe_done;
        logic out_busy;
        logic emit_more;
    } itg_status_t;

    // Program addresses.
    localparam upc_t UPC_IDLE       = upc_t'(0);
    localparam upc_t UPC_CHECK_N    = upc_t'(1);
    localparam upc_t UPC_CLEAR      = upc_t'(2);
    localparam upc_t UPC_PLACE      = upc_t'(3);
    localparam upc_t UPC_WRAP_TEST  = upc_t'(4);
    localparam upc_t UPC_PROBE      = upc_t'(5);
    localparam upc_t UPC_PROBE_READ = upc_t'(6);
    localparam upc_t UPC_EMIT_INIT  = upc_t'(7);
    localparam upc_t UPC_EMIT_READ  = upc_t'(8);
    localparam upc_t UPC_EMIT       = upc_t'(9);
    localparam upc_t UPC_EMIT_NEXT  = upc_t'(10);
    localparam upc_t UPC_DONE       = upc_t'(11);

    function automatic itg_ctl_t ucode_rom(input upc_t addr);
        itg_ctl_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: UPC_IDLE};
        case (addr)
            UPC_IDLE:       w = '{op: OP_LOAD,      cond: C_NO_REQ,     target: UPC_IDLE};
            UPC_CHECK_N:    w = '{op: OP_NOP,       cond: C_N_ZERO,     target: UPC_IDLE};
            UPC_CLEAR:      w = '{op: OP_CLEAR,     cond: C_CLR_MORE,   target: UPC_CLEAR};
            UPC_PLACE:      w = '{op: OP_PLACE,     cond: C_PLACE_DONE, target: UPC_EMIT_INIT};
            UPC_WRAP_TEST:  w = '{op: OP_NOP,       cond: C_NO_WRAP,    target: UPC_PLACE};
            UPC_PROBE:      w = '{op: OP_PROBE,     cond: C_PROBE_DONE, target: UPC_PLACE};
            UPC_PROBE_READ: w = '{op: OP_NOP,       cond: C_ALWAYS,     target: UPC_PROBE};
            UPC_EMIT_INIT:  w = '{op: OP_EMIT_INIT, cond: C_NEVER,      target: UPC_IDLE};
            UPC_EMIT_READ:  w = '{op: OP_NOP,       cond: C_NEVER,      target: UPC_IDLE};
            UPC_EMIT:       w = '{op: OP_EMIT,      cond: C_OUT_BUSY,   target: UPC_EMIT};
            UPC_EMIT_NEXT:  w = '{op: OP_NOP,       cond: C_EMIT_MORE,  target: UPC_EMIT};
            UPC_DONE:       w = '{op: OP_NOP,       cond: C_ALWAYS,     target: UPC_IDLE};
            default:        w = '{op: OP_NOP,       cond: C_ALWAYS,     target: UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/itg_sequencer.sv
// Microcode sequencer: step counter, program table lookup and jump logic.
// Depends on itg_pkg for the control word, status and program.
`default_nettype none

module itg_sequencer (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  itg_pkg::itg_status_t status,
    output itg_pkg::itg_ctl_t    ctl,
    output logic                 idle
);
    import itg_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic take;

    assign ctl  = ucode_rom(upc_reg);
    assign idle = (upc_reg == UPC_IDLE);

    always_comb
    begin
        case (ctl.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_REQ:     take = !in_valid;
            C_N_ZERO:     take = status.n_zero;
            C_CLR_MORE:   take = status.clr_more;
            C_PLACE_DONE: take = status.place_done;
            C_NO_WRAP:    take = status.no_wrap;
            C_PROBE_DONE: take = status.probe_done;
            C_OUT_BUSY:   take = status.out_busy;
            C_EMIT_MORE:  take = status.emit_more;
            default:      take = 1'b1;
        endcase
        upc_next = take ? ctl.target : upc_reg + upc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UPC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // The program counter never leaves the written part of the table.
    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= UPC_DONE)
        else $error("sequencer left the program");

    // A taken request always moves on to the count check.
    a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
        (idle && in_valid) |=> (upc_reg == UPC_CHECK_N))
        else $error("request not followed by count check");

    // Emission waits in place while the output register is full and stalled.
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UPC_EMIT && status.out_busy) |=> (upc_reg == UPC_EMIT))
        else $error("emit step left while output busy");

endmodule

`default_nettype wire

>>> hw/rtl/itg_datapath.sv
// Datapath: request registers, placement position and counters, the slot
// table memory and the output register. Driven by the sequencer control
// word; depends on itg_pkg.
`default_nettype none

module itg_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  itg_pkg::itg_ctl_t    ctl,
    input  wire                  in_valid,
    input  itg_pkg::itg_req_t    in_data,
    input  wire                  out_stall,
    output itg_pkg::itg_status_t status,
    output logic                 out_valid,
    output itg_pkg::itg_res_t    out_data
);
    import itg_pkg::*;

    logic [COUNT_W-1:0] n_reg,     n_next;
    logic [7:0]         start_reg, start_next;
    logic [SLOT_W-1:0]  step_reg,  step_next;
    logic [SLOT_W-1:0]  pos_reg,   pos_next;
    logic [COUNT_W-1:0] k_reg,     k_next;
    logic [COUNT_W-1:0] cnt_reg,   cnt_next;
    logic [COUNT_W-1:0] tries_reg, tries_next;
    logic               wrap_reg,  wrap_next;
    logic               out_valid_reg, out_valid_next;
    itg_res_t           out_reg,   out_next;

    logic [6:0]         mem [MAX_SECTORS];
    logic [6:0]         rdata_reg;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [6:0]         wr_data;

    logic [COUNT_W-1:0] n_sat;
    logic [COUNT_W-1:0] pos_sum;
    logic [COUNT_W-1:0] pos_inc;
    logic               out_free;
    logic               probe_stop;
    logic [7:0]         entry_ext;

    assign out_free   = !out_valid_reg || !out_stall;
    assign probe_stop = (rdata_reg == 7'd0) || (tries_reg == n_reg);
    assign pos_sum    = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_inc    = {1'b0, pos_reg} + COUNT_W'(1);
    assign entry_ext  = {1'b0, rdata_reg};

    always_comb
    begin
        if (in_data.sectors_per_track > 7'(MAX_SECTORS))
        begin
            n_sat = COUNT_W'(MAX_SECTORS);
        end
        else
        begin
            n_sat = COUNT_W'(in_data.sectors_per_track);
        end
    end

    always_comb
    begin
        n_next         = n_reg;
        start_next     = start_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        tries_next     = tries_reg;
        wrap_next      = wrap_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = k_reg;
        rd_addr        = pos_reg;

        case (ctl.op)
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    n_next     = n_sat;
                    start_next = in_data.start_sector;
                    // A zero interleave, or one at or beyond the count, means 1.
                    if (in_data.interleave == 8'd0 || in_data.interleave >= 8'(n_sat))
                    begin
                        step_next = SLOT_W'(1);
                    end
                    else
                    begin
                        step_next = in_data.interleave[SLOT_W-1:0];
                    end
                    pos_next   = '0;
                    k_next     = COUNT_W'(1);
                    cnt_next   = '0;
                    tries_next = '0;
                    wrap_next  = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[SLOT_W-1:0];
                wr_data  = 7'd0;
                cnt_next = cnt_reg + COUNT_W'(1);
            end
            OP_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = k_reg;
                k_next     = k_reg + COUNT_W'(1);
                tries_next = '0;
                // Sum stays below twice the count, so one subtract wraps it.
                if (pos_sum >= n_reg)
                begin
                    pos_next  = SLOT_W'(pos_sum - n_reg);
                    wrap_next = 1'b1;
                end
                else
                begin
                    pos_next  = pos_sum[SLOT_W-1:0];
                    wrap_next = 1'b0;
                end
            end
            OP_PROBE:
            begin
                if (!probe_stop)
                begin
                    pos_next   = (pos_inc == n_reg) ? '0 : pos_inc[SLOT_W-1:0];
                    tries_next = tries_reg + COUNT_W'(1);
                end
            end
            OP_EMIT_INIT:
            begin
                cnt_next = '0;
                rd_addr  = '0;
            end
            OP_EMIT:
            begin
                rd_addr = cnt_reg[SLOT_W-1:0];
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.slot_index  = cnt_reg[SLOT_W-1:0];
                    if (start_reg == 8'd0)
                    begin
                        out_next.sector_number = entry_ext - 8'd1;
                    end
                    else
                    begin
                        out_next.sector_number = entry_ext + start_reg - 8'd1;
                    end
                    out_next.last = ((cnt_reg + COUNT_W'(1)) == n_reg);
                    cnt_next      = cnt_reg + COUNT_W'(1);
                end
            end
            OP_NOP:
            begin
                rd_addr = (ctl.cond == C_PROBE_DONE || ctl.cond == C_NO_WRAP
                           || ctl.cond == C_ALWAYS) ? pos_reg : cnt_reg[SLOT_W-1:0];
            end
            default:
            begin
                rd_addr = pos_reg;
            end
        endcase
    end

    always_comb
    begin
        status.n_zero     = (n_reg == '0);
        status.clr_more   = ((cnt_reg + COUNT_W'(1)) != n_reg);
        status.place_done = (k_reg == n_reg);
        status.no_wrap    = !wrap_reg;
        status.probe_done = probe_stop;
        status.out_busy   = !out_free;
        status.emit_more  = (cnt_reg != n_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            start_reg     <= '0;
            step_reg      <= SLOT_W'(1);
            pos_reg       <= '0;
            k_reg         <= COUNT_W'(1);
            cnt_reg       <= '0;
            tries_reg     <= '0;
            wrap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            start_reg     <= start_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            tries_reg     <= tries_next;
            wrap_reg      <= wrap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Placement and probing stay inside the track.
    a_pos_in_track: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_PLACE || ctl.op == OP_PROBE) |-> (pos_reg < n_reg))
        else $error("position beyond track end");

    // The probe never takes more steps than there are slots.
    a_tries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tries_reg <= n_reg)
        else $error("probe ran past the slot count");

    // Slots are emitted only while the index is within the track.
    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_EMIT) |-> (cnt_reg < n_reg))
        else $error("emit index beyond track");

endmodule

`default_nettype wire

>>> hw/rtl/interleave_table_generator.sv
// Top level of the interleave table generator: microcode sequencer plus
// datapath with the slot table memory. Depends on itg_pkg, itg_sequencer
// and itg_datapath.
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall    itg_req_t (count, start, interleave)
//   out      out  out_valid / out_stall  itg_res_t (slot, sector, last)
//
// One request is worked on at a time: the block takes it and checks the count,
// clears the slot table, places each sector, and after each wrap probes for a
// free slot. Emission then reads the table and gives one result per slot.
// Reset clears the sequencer, counters and output valid; the table is cleared
// per request. The input stalls until the sequencer is back in idle, and a
// stalled output holds the emit step in place.
`default_nettype none

module interleave_table_generator (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  itg_pkg::itg_req_t  in_data,
    output logic               out_valid,
    input  wire                out_stall,
    output itg_pkg::itg_res_t  out_data
);
    import itg_pkg::*;

    itg_ctl_t    ctl;
    itg_status_t status;
    logic        idle;

    assign in_stall = !idle;

    itg_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctl      (ctl),
        .idle     (idle)
    );

    itg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_stall (out_stall),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> sim/tb_interleave_table_generator.sv
// Testbench for interleave_table_generator: directed and random format requests, each
// checked slot by slot against a behavioral interleave table model or an in-order list.
// Depends on itg_pkg and the interleave_table_generator RTL.
`timescale 1ns / 100ps

module tb_interleave_table_generator;
    import itg_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 600;
    localparam int TAIL_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int PHASE_ITEMS   = 85;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_IN_ORDER,
        ROW_EMPTY
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        itg_req_t  req;
    } track_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    itg_req_t in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    itg_res_t out_data;

    itg_res_t   expected_slots [$];
    track_row_t directed_rows [21];
    int         error_count = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_trigger = 0;
    int         hold_seen = 0;
    int         hold_left = 0;

    interleave_table_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off whenever the stimulus asks for one.
    always @(negedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        itg_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_slots.size() == 0)
            begin
                $error("unexpected result: slot_index %0d sector_number %0d last %0d",
                       out_data.slot_index, out_data.sector_number, out_data.last);
                error_count++;
            end
            else
            begin
                want = expected_slots.pop_front();
                if (out_data.slot_index !== want.slot_index)
                begin
                    $error("slot_index: expected %0d, actual %0d",
                           want.slot_index, out_data.slot_index);
                    error_count++;
                end
                if (out_data.sector_number !== want.sector_number)
                begin
                    $error("sector_number: expected %0d, actual %0d",
                           want.sector_number, out_data.sector_number);
                    error_count++;
                end
                if (out_data.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, out_data.last);
                    error_count++;
                end
            end
        end
    end

    function automatic int track_length(input itg_req_t req);
        return (req.sectors_per_track > MAX_SECTORS) ? MAX_SECTORS
                                                      : int'(req.sectors_per_track);
    endfunction

    // Places logical sectors 1..n on the track, then queues one result per slot.
    task automatic predict_track(input itg_req_t req);
        logic [6:0] slots [MAX_SECTORS];
        logic [7:0] number;
        itg_res_t   res;
        int         n;
        int         stride;
        int         pos;
        int         tries;
        int         k;
        int         s;
        begin
            n = track_length(req);
            stride = req.interleave;
            if (stride == 0 || stride >= n)
                stride = 1;
            for (s = 0; s < MAX_SECTORS; s++)
                slots[s] = '0;
            pos = 0;
            for (k = 1; k <= n; k++)
            begin
                slots[pos] = 7'(k);
                pos += stride;
                // Only a wrap past the track end probes for a free slot; a plain
                // landing on a used slot overwrites it.
                if (pos >= n)
                begin
                    pos = pos % n;
                    tries = 0;
                    while (tries < n && slots[pos] != '0)
                    begin
                        pos++;
                        if (pos >= n)
                            pos = 0;
                        tries++;
                    end
                end
            end
            for (s = 0; s < n; s++)
            begin
                number = {1'b0, slots[s]};
                if (req.start_sector == 8'd0)
                    number = number - 8'd1;
                else
                    number = number + req.start_sector - 8'd1;
                res.slot_index = 6'(s);
                res.sector_number = number;
                res.last = (s == n - 1);
                expected_slots.push_back(res);
            end
        end
    endtask

    // Interleave of one: the sectors simply count up from the start number.
    task automatic push_in_order(input itg_req_t req);
        itg_res_t res;
        int       n;
        int       s;
        begin
            n = track_length(req);
            for (s = 0; s < n; s++)
            begin
                res.slot_index = 6'(s);
                res.sector_number = (req.start_sector == 8'd0) ? 8'(s)
                                                               : 8'(req.start_sector + s);
                res.last = (s == n - 1);
                expected_slots.push_back(res);
            end
        end
    endtask

    function automatic track_row_t make_row(input row_kind_t kind, input int n,
                                            input int start, input int il);
        track_row_t row;
        row.kind = kind;
        row.req.sectors_per_track = 7'(n);
        row.req.start_sector = 8'(start);
        row.req.interleave = 8'(il);
        return row;
    endfunction

    function automatic track_row_t random_track();
        int pick;
        int n;
        int start;
        int il;
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                n = 0;
            else if (pick < 60)
                n = $urandom_range(16, 1);
            else if (pick < 88)
                n = $urandom_range(64, 17);
            else
                n = $urandom_range(127, 65);
            pick = $urandom_range(99);
            if (pick < 15)
                start = 0;
            else if (pick < 25)
                start = 1;
            else
                start = $urandom_range(255);
            pick = $urandom_range(99);
            if (pick < 55 && n > 2)
                il = $urandom_range((n > MAX_SECTORS ? MAX_SECTORS : n) - 1, 2);
            else if (pick < 65)
                il = $urandom_range(1, 0);
            else if (pick < 80)
                il = $urandom_range(255, (n > MAX_SECTORS ? MAX_SECTORS : n));
            else
                il = $urandom_range(255);
            return make_row(ROW_PREDICT, n, start, il);
        end
    endfunction

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance.
    task automatic send_request(input track_row_t row);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data <= row.req;
            do
                @(posedge clk);
            while (in_stall);
            case (row.kind)
                ROW_PREDICT:  predict_track(row.req);
                ROW_IN_ORDER: push_in_order(row.req);
                default:      ;
            endcase
            @(negedge clk);
        end
    endtask

    // Withdraws the request so the block does not take it a second time.
    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (expected_slots.size() != 0)
                @(negedge clk);
        end
    endtask

    initial
    begin
        int phase;
        int i;
        int send_pcts [4];
        int stall_pcts [4];

        send_pcts  = '{0, 74, 0, 38};
        stall_pcts = '{0, 0, 74, 38};

        directed_rows = '{
            make_row(ROW_IN_ORDER, 1, 0, 0),        // single sector, zero interleave
            make_row(ROW_EMPTY, 0, 5, 3),           // empty track gives no results
            make_row(ROW_IN_ORDER, 64, 255, 0),     // full track, numbers wrap past 255
            make_row(ROW_IN_ORDER, 127, 1, 255),    // count saturates, interleave too large
            make_row(ROW_IN_ORDER, 64, 0, 64),      // interleave equal to count
            make_row(ROW_IN_ORDER, 10, 1, 10),
            make_row(ROW_PREDICT, 10, 1, 9),        // largest usable interleave
            make_row(ROW_IN_ORDER, 2, 0, 1),
            make_row(ROW_PREDICT, 3, 1, 2),
            make_row(ROW_PREDICT, 8, 1, 2),
            make_row(ROW_PREDICT, 17, 1, 3),
            make_row(ROW_PREDICT, 64, 200, 63),
            make_row(ROW_PREDICT, 64, 0, 2),
            make_row(ROW_PREDICT, 6, 1, 4),
            make_row(ROW_IN_ORDER, 64, 128, 127),
            make_row(ROW_PREDICT, 33, 254, 32),
            make_row(ROW_PREDICT, 100, 0, 63),      // saturated count with interleave
            make_row(ROW_IN_ORDER, 1, 255, 255),
            make_row(ROW_IN_ORDER, 5, 85, 170),
            make_row(ROW_PREDICT, 42, 170, 21),
            make_row(ROW_PREDICT, 63, 1, 62)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < $size(directed_rows); i++)
            send_request(directed_rows[i]);
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_pcts[phase];
            stall_pct = stall_pcts[phase];
            for (i = 0; i < PHASE_ITEMS; i++)
                send_request(random_track());
            wait_drained();
        end

        // Hold the output off for a long time while requests keep coming, so the
        // block backs up and stalls its input.
        send_idle_pct = 0;
        stall_pct = 0;
        hold_trigger++;
        for (i = 0; i < 6; i++)
            send_request(random_track());
        wait_drained();

        send_idle_pct = 38;
        stall_pct = 38;
        for (i = 0; i < 10; i++)
            send_request(random_track());
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_slots.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/itg_pkg.sv
hw/rtl/itg_sequencer.sv
hw/rtl/itg_datapath.sv
hw/rtl/interleave_table_generator.sv
sim/tb_interleave_table_generator.sv
